// File: rtl/lse_pkg.sv
// Package with the shared types and codes of the LIFO stack engine.
`default_nettype none

package lse_pkg;

    // Opcodes of a command transfer.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_DUMP  = 3'd4;

    // Status codes of a result transfer.
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Word width of a stack entry.
    localparam int WORD_W = 32;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic                     status;
        logic [5:0]               depth_now;
        logic                     is_empty;
        logic                     last;
    } t_result;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

`default_nettype wire

// File: rtl/lse_mem.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module lse_mem
    import lse_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WORD_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/lse_ctrl.sv
// Stack controller: pointer, opcode decode, dump sequencer and result stage.
`default_nettype none

module lse_ctrl
    import lse_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int PTR_W  = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_cmd              i_cmd,
    output logic                   o_we,
    output logic      [ADDR_W-1:0] o_waddr,
    output logic      [WORD_W-1:0] o_wdata,
    output logic      [ADDR_W-1:0] o_raddr,
    input  wire logic [WORD_W-1:0] i_rdata,
    output logic                   o_strobe,
    output t_result                o_result
);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_sp, n_sp;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_valid, n_valid;
    logic              r_status, n_status;
    logic              r_use_rd, n_use_rd;
    logic              accept;
    logic              is_dump;
    logic              dump_last;
    logic              sp_empty;
    logic              sp_full;
    logic [6:0]        sp_ext;

    assign is_dump   = (r_state == ST_DUMP);
    assign accept    = start && !is_dump;
    assign sp_empty  = (r_sp == '0);
    assign sp_full   = (r_sp == PTR_W'(DEPTH));
    assign dump_last = ((PTR_W'(r_idx) + PTR_W'(1)) == r_sp);
    assign busy      = is_dump;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sp    <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_use_rd <= n_use_rd;
    end

    // Next state, memory requests and result of an accepted transfer.
    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_status = r_status;
        n_use_rd = r_use_rd;
        o_we     = 1'b0;
        o_waddr  = ADDR_W'(r_sp);
        o_wdata  = i_cmd.push_value;
        o_raddr  = ADDR_W'(r_sp - PTR_W'(1));
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid  = 1'b1;
                    n_status = STAT_ERR;
                    n_use_rd = 1'b0;
                    case (i_cmd.opcode)
                        OP_PUSH: begin
                            if (!sp_full) begin
                                o_we     = 1'b1;
                                n_sp     = r_sp + PTR_W'(1);
                                n_status = STAT_OK;
                            end
                        end
                        OP_POP: begin
                            if (!sp_empty) begin
                                n_sp     = r_sp - PTR_W'(1);
                                n_status = STAT_OK;
                                n_use_rd = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (!sp_empty) begin
                                n_status = STAT_OK;
                                n_use_rd = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_sp     = '0;
                            n_status = STAT_OK;
                        end
                        OP_DUMP: begin
                            // A non-empty dump starts reading at the bottom entry.
                            if (!sp_empty) begin
                                n_valid = 1'b0;
                                n_state = ST_DUMP;
                                n_idx   = '0;
                                o_raddr = '0;
                            end
                        end
                        default: begin
                            n_status = STAT_ERR;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                // One entry per cycle; the read for the next one goes out now.
                if (dump_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    o_raddr = r_idx + ADDR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result transfer: dump entries come straight from the read port.
    assign sp_ext   = 7'(r_sp);
    assign o_strobe = r_valid || is_dump;

    always_comb begin
        o_result.status     = is_dump ? STAT_OK : r_status;
        o_result.read_value = (is_dump || r_use_rd) ? i_rdata : '0;
        o_result.depth_now  = sp_ext[5:0];
        o_result.is_empty   = sp_empty;
        o_result.last       = is_dump ? dump_last : 1'b1;
    end

endmodule

`default_nettype wire

// File: rtl/lifo_stack_engine_core.sv
// A result appears in the cycle after its command transfer; a dump emits one per entry.
// Push, pop, peek and clear may follow back to back while busy is low.
// A dump holds busy while it emits its entries, as the store has a single read port.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
// Reset is synchronous and active low; it empties the stack, the store itself is not cleared.
`default_nettype none

module lifo_stack_engine_core
    import lse_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    // Stack controller.
    lse_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .PTR_W  (PTR_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Entry store.
    lse_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

`ifndef SYNTHESIS
    // Every busy cycle belongs to a dump and carries one entry.
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_strobe)
        else $error("busy without a dump result");

    // A command other than dump yields one final result in the next cycle.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode != OP_DUMP) |=> (o_strobe && o_result.last))
        else $error("missing result after a command transfer");

    // Error results never carry a word.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == STAT_ERR) |-> (o_result.read_value == '0))
        else $error("error result with a nonzero word");
`endif

endmodule

`default_nettype wire
